FILE: hdl/bsfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
// No dependencies; imported by bsfr_step and byte_stuffed_frame_receiver.
package bsfr_pkg;

  localparam logic [7:0] MARK_BYTE  = 8'hAA;
  localparam logic [7:0] START_BYTE = 8'hCC;
  localparam logic [7:0] END_BYTE   = 8'hEE;
  localparam int unsigned MIN_FRAME    = 6;
  localparam int unsigned MIN_ADDR_LEN = 3;
  localparam int unsigned SLAVE_POS    = 0;
  localparam int unsigned CMD_POS      = 2;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_SLAVE    = 1'b0,
    REG_EXPECTED_CMD = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LVL_HUNT = 2'd0,
    LVL_HEAD = 2'd1,
    LVL_DATA = 2'd2,
    LVL_MARK = 2'd3
  } level_e;

  typedef enum logic [2:0] {
    EV_DATA     = 3'd0,
    EV_RESTART  = 3'd1,
    EV_OK       = 3'd2,
    EV_MISMATCH = 3'd3,
    EV_SHORT    = 3'd4,
    EV_OVERFLOW = 3'd5
  } event_e;

  // Framing state apart from the byte count.
  typedef struct packed {
    level_e     level;
    logic [7:0] seen_slave;
    logic [7:0] seen_cmd;
  } frame_state_t;

  // One result item.
  typedef struct packed {
    event_e     kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [8:0] frame_length;
  } result_t;

endpackage

FILE: hdl/bsfr_step.sv
// Next-state and result logic for one received byte of the frame receiver.
// Depends on bsfr_pkg.
module bsfr_step #(
  parameter int unsigned BUFFER_BYTES = 256,
  parameter int unsigned CNT_W        = $clog2(BUFFER_BYTES + 1)
) (
  input  bsfr_pkg::frame_state_t state_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [7:0]             own_slave_i,
  input  logic [7:0]             expected_cmd_i,
  input  logic [7:0]             rx_byte_i,
  output bsfr_pkg::frame_state_t state_o,
  output logic [CNT_W-1:0]       count_o,
  output logic                   emit_o,
  output bsfr_pkg::result_t      result_o
);
  import bsfr_pkg::*;

  logic [31:0] cnt_wide;
  logic        store;

  assign cnt_wide = 32'(count_i);

  always_comb begin
    state_o  = state_i;
    count_o  = count_i;
    emit_o   = 1'b0;
    store    = 1'b0;
    result_o = '{kind: EV_DATA, data_byte: 8'd0, byte_index: 8'd0,
                 frame_length: cnt_wide[8:0]};

    if (count_i == CNT_W'(BUFFER_BYTES)) begin
      // Buffer full: drop the byte and flag overflow.
      emit_o        = 1'b1;
      result_o.kind = EV_OVERFLOW;
      state_o.level = LVL_HUNT;
      count_o       = '0;
    end else begin
      case (state_i.level)
        LVL_HUNT: begin
          if (rx_byte_i == MARK_BYTE) state_o.level = LVL_HEAD;
        end
        LVL_HEAD: begin
          if (rx_byte_i == START_BYTE) begin
            state_o.level = LVL_DATA;
            count_o       = '0;
          end else begin
            state_o.level = LVL_HUNT;
          end
        end
        LVL_DATA: begin
          if (rx_byte_i == MARK_BYTE) state_o.level = LVL_MARK;
          else                        store = 1'b1;
        end
        LVL_MARK: begin
          if (rx_byte_i == MARK_BYTE) begin
            state_o.level = LVL_DATA;
            store         = 1'b1;
          end else if (rx_byte_i == START_BYTE) begin
            emit_o        = 1'b1;
            result_o.kind = EV_RESTART;
            state_o.level = LVL_DATA;
            count_o       = '0;
          end else if (rx_byte_i == END_BYTE) begin
            emit_o = 1'b1;
            if (count_i < CNT_W'(MIN_ADDR_LEN) || state_i.seen_slave != own_slave_i ||
                state_i.seen_cmd != expected_cmd_i) begin
              result_o.kind = EV_MISMATCH;
            end else if (count_i < CNT_W'(MIN_FRAME)) begin
              result_o.kind = EV_SHORT;
            end else begin
              result_o.kind = EV_OK;
            end
            state_o.level = LVL_HUNT;
            count_o       = '0;
          end
          // any other byte: ignore, marker stays pending
        end
        default: state_o.level = LVL_HUNT;
      endcase
    end

    if (store) begin
      emit_o                = 1'b1;
      result_o.kind         = EV_DATA;
      result_o.data_byte    = rx_byte_i;
      result_o.byte_index   = cnt_wide[7:0];
      result_o.frame_length = 9'd0;
      count_o               = count_i + CNT_W'(1);
      if (count_i == CNT_W'(SLAVE_POS)) state_o.seen_slave = rx_byte_i;
      if (count_i == CNT_W'(CMD_POS))   state_o.seen_cmd   = rx_byte_i;
    end
  end

endmodule

FILE: hdl/byte_stuffed_frame_receiver.sv
// Top level of the byte-stuffed frame receiver: framing state, config
// registers and output register. Depends on bsfr_pkg and bsfr_step.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, rx_byte_i) takes one raw line byte
//   per request. Frames open with AA CC and close with AA EE; AA AA inside a
//   frame is one AA data byte, AA CC inside a frame restarts it.
//   Output channel (out_valid_o/out_ready_i) carries at most one event per
//   input byte: a payload byte with its index, a restart, or a tail verdict
//   (ok, mismatch, too short) or overflow with the frame length.
//   Config channel (cfg_valid_i/cfg_ready_o) writes own_slave (index 0) and
//   expected_cmd (index 1); it is always ready. Write only while idle.
// Timing:
//   An event appears on the output in the cycle after its input byte is taken.
//   One byte per cycle is sustained: a byte is taken whenever the output
//   register is empty or is being emptied in the same cycle, so
//   in_ready_o follows out_ready_i combinationally once a result is held.
// Reset and stall:
//   Reset returns to hunting for a header with an empty count and clears both
//   config registers. While the receiver stalls, the held event stays on the
//   output and input bytes are taken only as the output register drains.
module byte_stuffed_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        event_kind_o,
  output logic [7:0]                        data_byte_o,
  output logic [7:0]                        byte_index_o,
  output logic [8:0]                        frame_length_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [7:0]                        cfg_wdata_i
);
  import bsfr_pkg::*;

  // Count holds 0..BUFFER_BYTES inclusive.
  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);

  frame_state_t     state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       own_slave_q, expected_cmd_q;
  logic             out_valid_q;
  result_t          result_q;
  logic             emit;
  result_t          result_d;
  logic             in_take;

  // Take a byte when the output register is free or draining now.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  bsfr_step #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .CNT_W        (CNT_W)
  ) u_step (
    .state_i        (state_q),
    .count_i        (count_q),
    .own_slave_i    (own_slave_q),
    .expected_cmd_i (expected_cmd_q),
    .rx_byte_i      (rx_byte_i),
    .state_o        (state_d),
    .count_o        (count_d),
    .emit_o         (emit),
    .result_o       (result_d)
  );

  // Framing state and config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= '{level: LVL_HUNT, seen_slave: 8'd0, seen_cmd: 8'd0};
      count_q        <= '0;
      own_slave_q    <= 8'd0;
      expected_cmd_q <= 8'd0;
    end else begin
      if (in_take) begin
        state_q <= state_d;
        count_q <= count_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_OWN_SLAVE:    own_slave_q    <= cfg_wdata_i;
          REG_EXPECTED_CMD: expected_cmd_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Output valid: set by an emitting byte, clear once the request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: load only with a new event, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_take && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = result_q.kind;
  assign data_byte_o    = result_q.data_byte;
  assign byte_index_o   = result_q.byte_index;
  assign frame_length_o = result_q.frame_length;

endmodule

FILE: verif/byte_stuffed_frame_receiver_tb.sv
// Self-checking testbench for byte_stuffed_frame_receiver: drives raw line bytes and
// compares every output event with a predictor of the deframing rules.
// Depends on bsfr_pkg (hdl/bsfr_pkg.sv) and the RTL of the block.
module byte_stuffed_frame_receiver_tb;
  import bsfr_pkg::*;

  localparam int unsigned FRAME_BUF   = 256;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BYTES = 40;

  // Track expected events: own copy of framing state, registers and a queue of
  // events still due from the block.
  class frame_event_board;
    logic [7:0]  own_slave;
    logic [7:0]  expected_cmd;
    level_e      level;
    logic [8:0]  count;
    logic [7:0]  seen_slave;
    logic [7:0]  seen_cmd;
    result_t     due_events[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned kind_hits[6];

    function new();
      own_slave    = '0;
      expected_cmd = '0;
      level        = LVL_HUNT;
      count        = '0;
      seen_slave   = '0;
      seen_cmd     = '0;
      errors       = 0;
      checked      = 0;
      foreach (kind_hits[k]) kind_hits[k] = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [7:0] val);
      if (idx == REG_OWN_SLAVE) own_slave = val;
      else expected_cmd = val;
    endfunction

    function void due(event_e kind, logic [7:0] data, logic [7:0] idx, logic [8:0] len);
      result_t r;
      r.kind         = kind;
      r.data_byte    = data;
      r.byte_index   = idx;
      r.frame_length = len;
      due_events.push_back(r);
    endfunction

    function void store_byte(logic [7:0] b);
      if (count == SLAVE_POS) seen_slave = b;
      if (count == CMD_POS) seen_cmd = b;
      due(EV_DATA, b, count[7:0], '0);
      count = count + 1'b1;
    endfunction

    // Advance the framing state by one accepted line byte.
    function void note_byte(logic [7:0] b);
      event_e verdict;
      if (count >= FRAME_BUF) begin
        due(EV_OVERFLOW, '0, '0, count);
        level = LVL_HUNT;
        count = '0;
        return;
      end
      case (level)
        LVL_HUNT: begin
          if (b == MARK_BYTE) level = LVL_HEAD;
        end
        LVL_HEAD: begin
          if (b == START_BYTE) begin
            level = LVL_DATA;
            count = '0;
          end else begin
            level = LVL_HUNT;
          end
        end
        LVL_DATA: begin
          if (b == MARK_BYTE) level = LVL_MARK;
          else store_byte(b);
        end
        default: begin
          if (b == MARK_BYTE) begin
            level = LVL_DATA;
            store_byte(b);
          end else if (b == START_BYTE) begin
            due(EV_RESTART, '0, '0, count);
            level = LVL_DATA;
            count = '0;
          end else if (b == END_BYTE) begin
            if (count < MIN_ADDR_LEN || seen_slave != own_slave || seen_cmd != expected_cmd)
              verdict = EV_MISMATCH;
            else if (count < MIN_FRAME)
              verdict = EV_SHORT;
            else
              verdict = EV_OK;
            due(verdict, '0, '0, count);
            level = LVL_HUNT;
            count = '0;
          end
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_event(logic [2:0] kind, logic [7:0] data, logic [7:0] idx, logic [8:0] len);
      result_t want;
      if (due_events.size() == 0) begin
        report($sformatf("event kind %0d with nothing due", kind));
        return;
      end
      want = due_events.pop_front();
      checked++;
      if (kind !== want.kind)
        report($sformatf("event_kind %0d, want %0d", kind, want.kind));
      else if (want.kind <= EV_OVERFLOW)
        kind_hits[want.kind]++;
      if (data !== want.data_byte)
        report($sformatf("data_byte %0h, want %0h", data, want.data_byte));
      if (idx !== want.byte_index)
        report($sformatf("byte_index %0d, want %0d", idx, want.byte_index));
      if (len !== want.frame_length)
        report($sformatf("frame_length %0d, want %0d", len, want.frame_length));
    endtask
  endclass

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  cfg_reg_e   cfg_index = REG_OWN_SLAVE;
  logic [7:0] cfg_wdata = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] event_kind_o;
  logic [7:0] data_byte_o;
  logic [7:0] byte_index_o;
  logic [8:0] frame_length_o;
  logic       cfg_ready_o;

  frame_event_board board;
  logic [7:0]       line_q[$];
  bit               hold_req    = 1'b0;
  int unsigned      cycle_count = 0;
  int unsigned      bytes_sent  = 0;

  byte_stuffed_frame_receiver #(
    .BUFFER_BYTES(FRAME_BUF)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .event_kind_o  (event_kind_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .frame_length_o(frame_length_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run; the limit is far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("byte_stuffed_frame_receiver regression: fail");
      $finish;
    end
  end

  // Check each event at the negative edge: inputs only move at the rising edge,
  // so the values seen here are the ones the next rising edge will take.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready)
      board.check_event(event_kind_o, data_byte_o, byte_index_o, frame_length_o);
  end

  // Receiver side: switch among stall patterns at random intervals; on request
  // hold ready low for a long stretch so the output register fills and the block
  // stalls its input.
  initial begin : sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (tick % 3 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one byte and hold it until the request is taken. Call at a rising edge.
  task automatic push_byte(input logic [7:0] b);
    bit taken;
    in_valid <= 1'b1;
    rx_byte  <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    board.note_byte(b);
    bytes_sent++;
  endtask

  // Drain the line queue in bursts of random length with random gaps.
  task automatic drive_line();
    int unsigned burst;
    int unsigned gap;
    while (line_q.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && line_q.size() != 0) begin
        push_byte(line_q.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Write both registers back to back; only call while the block is idle.
  task automatic write_regs(input logic [7:0] slave, input logic [7:0] cmd);
    bit taken;
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? REG_OWN_SLAVE : REG_EXPECTED_CMD;
      cfg_wdata <= (r == 0) ? slave : cmd;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk_i);
        taken = cfg_ready_o;
        @(posedge clk_i);
      end
      board.set_reg((r == 0) ? REG_OWN_SLAVE : REG_EXPECTED_CMD, (r == 0) ? slave : cmd);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait until every due event has come, then let the pipeline settle.
  task automatic wait_drained();
    while (board.due_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Stuff a data byte: a marker inside a frame is sent twice.
  function automatic void queue_data(logic [7:0] b);
    if (b == MARK_BYTE) line_q.push_back(MARK_BYTE);
    line_q.push_back(b);
  endfunction

  // Queue one frame with random content; sometimes corrupt the address bytes,
  // slip in a stray marker, restart midway or leave the tail off.
  task automatic queue_frame(input int unsigned len);
    logic [7:0]  b;
    bit          addr_ok;
    int unsigned cut;
    addr_ok = ($urandom_range(0, 3) != 0);
    cut     = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len) : len + 1;
    line_q.push_back(MARK_BYTE);
    line_q.push_back(START_BYTE);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == cut) begin
        line_q.push_back(MARK_BYTE);
        line_q.push_back(START_BYTE);
      end
      if (i == SLAVE_POS && addr_ok)
        b = board.own_slave;
      else if (i == CMD_POS && addr_ok)
        b = board.expected_cmd;
      else
        b = ($urandom_range(0, 5) == 0) ? MARK_BYTE : 8'($urandom_range(0, 255));
      queue_data(b);
      if ($urandom_range(0, 24) == 0) begin
        do b = 8'($urandom_range(0, 255));
        while (b == MARK_BYTE || b == START_BYTE || b == END_BYTE);
        line_q.push_back(MARK_BYTE);
        line_q.push_back(b);
      end
    end
    if ($urandom_range(0, 14) != 0) begin
      line_q.push_back(MARK_BYTE);
      line_q.push_back(END_BYTE);
    end
  endtask

  // Mostly short frames, a few longer ones, and some line noise in between.
  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned n;
    while (line_q.size() < n_bytes) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) begin
          line_q.push_back(MARK_BYTE);
          line_q.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        queue_frame(n);
      end
    end
  endtask

  // Queue a frame of n counting bytes; slave and command slots take 0xFF.
  task automatic queue_long_frame(input int unsigned n);
    line_q.push_back(MARK_BYTE);
    line_q.push_back(START_BYTE);
    for (int unsigned i = 0; i < n; i++)
      queue_data((i == SLAVE_POS || i == CMD_POS) ? 8'hFF : 8'(i));
  endtask

  initial begin : main
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored byte while hunting, bad header, fresh header, stuffed
    // marker, stray byte after a marker, a good tail, a restart inside a frame,
    // an empty frame (mismatch) and a three-byte frame (too short).
    write_regs(8'h00, 8'h00);
    line_q = '{8'h00, MARK_BYTE, 8'h55, MARK_BYTE, START_BYTE,
               8'h00, MARK_BYTE, MARK_BYTE, 8'h00, 8'hFF, 8'h12, 8'h34,
               MARK_BYTE, 8'h77, END_BYTE,
               MARK_BYTE, START_BYTE, 8'h01, MARK_BYTE, START_BYTE, MARK_BYTE, END_BYTE,
               MARK_BYTE, START_BYTE, 8'h00, 8'h01, 8'h00, MARK_BYTE, END_BYTE};
    drive_line();
    wait_drained();

    // Full-size frames: the longest frame that can still close, then two that
    // overflow, one on a marker and one on a plain byte.
    write_regs(8'hFF, 8'hFF);
    queue_long_frame(FRAME_BUF - 1);
    line_q.push_back(MARK_BYTE);
    line_q.push_back(END_BYTE);
    queue_long_frame(FRAME_BUF);
    line_q.push_back(MARK_BYTE);
    queue_long_frame(FRAME_BUF);
    line_q.push_back(8'h5A);
    drive_line();
    wait_drained();

    // Random traffic under three register settings; the second uses the marker
    // and start codes as address values, so the marker is stuffed in the frame.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1)
        write_regs(MARK_BYTE, START_BYTE);
      else
        write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      queue_random_traffic(PHASE_BYTES);
      if (ph == 0) hold_req = 1'b1;
      drive_line();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d line bytes, %0d events: %0d data, %0d restart, %0d ok,",
             bytes_sent, board.checked, board.kind_hits[EV_DATA],
             board.kind_hits[EV_RESTART], board.kind_hits[EV_OK]);
    $display("  %0d mismatch, %0d too short, %0d overflow; %0d errors",
             board.kind_hits[EV_MISMATCH], board.kind_hits[EV_SHORT],
             board.kind_hits[EV_OVERFLOW], board.errors);
    if (board.errors == 0 && board.due_events.size() == 0)
      $display("byte_stuffed_frame_receiver regression: pass");
    else
      $display("byte_stuffed_frame_receiver regression: fail");
    $finish;
  end

endmodule

FILE: byte_stuffed_frame_receiver.f
hdl/bsfr_pkg.sv
hdl/bsfr_step.sv
hdl/byte_stuffed_frame_receiver.sv
verif/byte_stuffed_frame_receiver_tb.sv
